[hw/rtl/sal_pkg.sv]
// Shared types and constants for the set-associative LRU cache.
// Holds the configuration register map, result status codes and geometry struct.
// No dependencies; every other file of the cache imports this package.
package sal_pkg;

    // Width of the per-line recency stamp and the per-set use counter.
    localparam int STAMP_W = 32;

    // Configuration register widths.
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 4;

    // Configuration write channel.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS       = 2'd2;

    // Configuration reset values.
    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd8;

    // Largest offset width that is honored.
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_MAX = 5'd16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MISS  = 2'd0,
        ST_HIT   = 2'd1,
        ST_EVICT = 2'd2,
        ST_FLUSH = 2'd3
    } status_t;

    // Effective geometry after clamping the raw register values.
    typedef struct packed {
        logic [SET_BITS_W-1:0]   set_bits;
        logic [BLOCK_BITS_W-1:0] block_bits;
        logic [WAYS_W-1:0]       ways;
    } geom_t;

endpackage

[hw/rtl/set_assoc_lru_cache.sv]
// Top level of the set-associative cache with LRU replacement.
// Instantiates sal_cfg, sal_mem and sal_ctrl; depends on sal_pkg.
//
//  Channel  Direction  Handshake          Payload
//  cfg      in         cfg_valid/ready    cfg_index, cfg_data
//  s        in         s_tvalid/tready    s_tuser = mode, s_tdata = address
//  m        out        m_tvalid/tready    m_tuser = status, m_tdata = req_block, evict_block
//
// Each request passes through accept, then a store read and a compare pass per way in
// use, then write-back and hand-off to the output register.
// After reset a clearing pass writes every line and counter entry, one per cycle,
// 2^(clog2(MAX_SETS) + clog2(MAX_WAYS)) line entries in all (512 at the defaults);
// s_tready stays low meanwhile, configuration writes are taken as ever.
// A result waiting in the output register holds the next request in its last state.
module set_assoc_lru_cache #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 48,
    localparam int IN_W      = ((ADDR_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * ADDR_WIDTH + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sal_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sal_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // address
    input  logic                             s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,   // req_block, evict_block
    output logic [1:0]                       m_tuser    // status
);
    import sal_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int IDX_W  = SET_W + WAY_W;
    localparam int LINE_W = 1 + STAMP_W + ADDR_WIDTH;

    geom_t                 geom;
    status_t               out_status;
    logic [ADDR_WIDTH-1:0] out_insert;
    logic [ADDR_WIDTH-1:0] out_victim;
    logic                  line_rd_en;
    logic [IDX_W-1:0]      line_rd_addr;
    logic [LINE_W-1:0]     line_rd_data;
    logic                  line_wr_en;
    logic [IDX_W-1:0]      line_wr_addr;
    logic [LINE_W-1:0]     line_wr_data;
    logic                  clk_rd_en;
    logic [SET_W-1:0]      clk_rd_addr;
    logic [STAMP_W-1:0]    clk_rd_data;
    logic                  clk_wr_en;
    logic [SET_W-1:0]      clk_wr_addr;
    logic [STAMP_W-1:0]    clk_wr_data;

    // Configuration registers.
    sal_cfg #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // Line and counter stores.
    sal_mem #(
        .SET_W      (SET_W),
        .WAY_W      (WAY_W),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_mem (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_rd_en   (line_rd_en),
        .line_rd_addr (line_rd_addr),
        .line_rd_data (line_rd_data),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .clk_rd_en    (clk_rd_en),
        .clk_rd_addr  (clk_rd_addr),
        .clk_rd_data  (clk_rd_data),
        .clk_wr_en    (clk_wr_en),
        .clk_wr_addr  (clk_wr_addr),
        .clk_wr_data  (clk_wr_data)
    );

    // Sequencer with the shared compare unit.
    sal_ctrl #(
        .SET_W      (SET_W),
        .WAY_W      (WAY_W),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (s_tuser),
        .in_address   (s_tdata[ADDR_WIDTH-1:0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_insert   (out_insert),
        .out_victim   (out_victim),
        .line_rd_en   (line_rd_en),
        .line_rd_addr (line_rd_addr),
        .line_rd_data (line_rd_data),
        .line_wr_en   (line_wr_en),
        .line_wr_addr (line_wr_addr),
        .line_wr_data (line_wr_data),
        .clk_rd_en    (clk_rd_en),
        .clk_rd_addr  (clk_rd_addr),
        .clk_rd_data  (clk_rd_data),
        .clk_wr_en    (clk_wr_en),
        .clk_wr_addr  (clk_wr_addr),
        .clk_wr_data  (clk_wr_data)
    );

    // Pack the result: request block in the low bits, evicted block above it.
    assign m_tdata = OUT_W'({out_victim, out_insert});
    assign m_tuser = out_status;

endmodule

[hw/rtl/sal_cfg.sv]
// Configuration registers of the set-associative LRU cache.
// Stores the raw register values and derives the clamped geometry.
// Depends on sal_pkg.
module sal_cfg #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sal_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sal_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sal_pkg::geom_t                   geom
);
    import sal_pkg::*;

    // Largest set-select width whose set count still fits in the array.
    localparam int SET_CAP_I   = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_RAW_MAX = (1 << SET_BITS_W) - 1;
    localparam logic [SET_BITS_W-1:0] SET_CAP =
        SET_BITS_W'((SET_CAP_I > SET_RAW_MAX) ? SET_RAW_MAX : SET_CAP_I);

    // Largest way count that is honored.
    localparam int WAY_RAW_MAX = (1 << WAYS_W) - 1;
    localparam logic [WAYS_W-1:0] WAY_CAP =
        WAYS_W'((MAX_WAYS > WAY_RAW_MAX) ? WAY_RAW_MAX : MAX_WAYS);

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;

    // Writes are always taken; writes beyond the register map are dropped.
    assign cfg_ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the raw values into the supported geometry.
    always_comb
    begin
        geom.set_bits   = (set_bits_reg > SET_CAP) ? SET_CAP : set_bits_reg;
        geom.block_bits = (block_bits_reg > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX
                                                            : block_bits_reg;
        if (ways_reg == '0)
            geom.ways = WAYS_W'(1);
        else if (ways_reg > WAY_CAP)
            geom.ways = WAY_CAP;
        else
            geom.ways = ways_reg;
    end

endmodule

[hw/rtl/sal_mem.sv]
// Line store and per-set use counter store of the set-associative LRU cache.
// Each line word packs {valid, stamp, block}; reads are registered.
// Depends on sal_pkg.
module sal_mem #(
    parameter int SET_W      = 6,
    parameter int WAY_W      = 3,
    parameter int ADDR_WIDTH = 48,
    localparam int LINE_W    = 1 + sal_pkg::STAMP_W + ADDR_WIDTH,
    localparam int IDX_W     = SET_W + WAY_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        line_rd_en,
    input  logic [IDX_W-1:0]            line_rd_addr,
    output logic [LINE_W-1:0]           line_rd_data,
    input  logic                        line_wr_en,
    input  logic [IDX_W-1:0]            line_wr_addr,
    input  logic [LINE_W-1:0]           line_wr_data,
    input  logic                        clk_rd_en,
    input  logic [SET_W-1:0]            clk_rd_addr,
    output logic [sal_pkg::STAMP_W-1:0] clk_rd_data,
    input  logic                        clk_wr_en,
    input  logic [SET_W-1:0]            clk_wr_addr,
    input  logic [sal_pkg::STAMP_W-1:0] clk_wr_data
);
    import sal_pkg::*;

    localparam int LINE_DEPTH = 1 << IDX_W;
    localparam int SET_DEPTH  = 1 << SET_W;

    logic [LINE_W-1:0]  line_mem [LINE_DEPTH];
    logic [STAMP_W-1:0] clock_mem [SET_DEPTH];
    logic [LINE_W-1:0]  line_rd_data_reg;
    logic [STAMP_W-1:0] clk_rd_data_reg;

    // Line store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (line_wr_en)
            line_mem[line_wr_addr] <= line_wr_data;
        if (line_rd_en)
            line_rd_data_reg <= line_mem[line_rd_addr];
    end

    // Per-set use counters.
    always_ff @(posedge clk)
    begin
        if (clk_wr_en)
            clock_mem[clk_wr_addr] <= clk_wr_data;
        if (clk_rd_en)
            clk_rd_data_reg <= clock_mem[clk_rd_addr];
    end

    assign line_rd_data = line_rd_data_reg;
    assign clk_rd_data  = clk_rd_data_reg;

    // The sequencer never reads and writes the line store in the same cycle.
    a_line_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        line_wr_en |-> !line_rd_en)
        else $error("line store read and written in the same cycle");

endmodule

[hw/rtl/sal_ctrl.sv]
// Sequencer and shared compare unit of the set-associative LRU cache.
// Clears the stores after reset, scans one way per pass, then writes back.
// Depends on sal_pkg; drives the stores in sal_mem.
module sal_ctrl #(
    parameter int SET_W      = 6,
    parameter int WAY_W      = 3,
    parameter int ADDR_WIDTH = 48,
    localparam int LINE_W    = 1 + sal_pkg::STAMP_W + ADDR_WIDTH,
    localparam int IDX_W     = SET_W + WAY_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sal_pkg::geom_t              geom,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_mode,
    input  logic [ADDR_WIDTH-1:0]       in_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sal_pkg::status_t            out_status,
    output logic [ADDR_WIDTH-1:0]       out_insert,
    output logic [ADDR_WIDTH-1:0]       out_victim,
    output logic                        line_rd_en,
    output logic [IDX_W-1:0]            line_rd_addr,
    input  logic [LINE_W-1:0]           line_rd_data,
    output logic                        line_wr_en,
    output logic [IDX_W-1:0]            line_wr_addr,
    output logic [LINE_W-1:0]           line_wr_data,
    output logic                        clk_rd_en,
    output logic [SET_W-1:0]            clk_rd_addr,
    input  logic [sal_pkg::STAMP_W-1:0] clk_rd_data,
    output logic                        clk_wr_en,
    output logic [SET_W-1:0]            clk_wr_addr,
    output logic [sal_pkg::STAMP_W-1:0] clk_wr_data
);
    import sal_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [IDX_W-1:0]        clr_cnt_reg;

    // Request context.
    logic                    mode_reg;
    logic [ADDR_WIDTH-1:0]   block_reg;
    logic [SET_W-1:0]        set_reg;
    logic [WAY_W-1:0]        way_reg;

    // Scan results.
    logic                    hit_found_reg;
    logic [WAY_W-1:0]        hit_way_reg;
    logic                    free_found_reg;
    logic [WAY_W-1:0]        free_way_reg;
    logic [STAMP_W-1:0]      min_stamp_reg;
    logic [WAY_W-1:0]        min_way_reg;
    logic [ADDR_WIDTH-1:0]   min_block_reg;

    // Finished result and output register.
    status_t                 res_status_reg;
    logic [ADDR_WIDTH-1:0]   res_victim_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [ADDR_WIDTH-1:0]   out_insert_reg;
    logic [ADDR_WIDTH-1:0]   out_victim_reg;

    logic                    accept;
    logic                    out_load;
    logic [ADDR_WIDTH-1:0]   shifted;
    logic [ADDR_WIDTH-1:0]   in_block;
    logic [SET_W:0]          set_one;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        in_set;
    logic [WAY_W-1:0]        last_way;
    logic [WAY_W-1:0]        fill_way;
    logic                    rd_valid;
    logic [STAMP_W-1:0]      rd_stamp;
    logic [ADDR_WIDTH-1:0]   rd_block;
    logic                    rd_match;
    logic                    rd_lower;
    logic [STAMP_W-1:0]      new_stamp;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Split the incoming address into block address and set index.
    assign shifted  = in_address >> geom.block_bits;
    assign in_block = shifted << geom.block_bits;
    assign set_one  = (SET_W + 1)'(1) << geom.set_bits;
    assign set_mask = SET_W'(set_one - 1'b1);
    assign in_set   = shifted[SET_W-1:0] & set_mask;
    assign last_way = WAY_W'(geom.ways - 4'd1);

    // Shared compare unit on the line word read back from the store.
    assign rd_valid  = line_rd_data[LINE_W-1];
    assign rd_stamp  = line_rd_data[LINE_W-2 -: STAMP_W];
    assign rd_block  = line_rd_data[ADDR_WIDTH-1:0];
    assign rd_match  = rd_valid && (rd_block == block_reg);
    assign rd_lower  = (rd_stamp < min_stamp_reg);
    assign new_stamp = clk_rd_data + STAMP_W'(1);

    // Way to refill: the hit way, else the first free way, else the LRU way.
    assign fill_way = hit_found_reg  ? hit_way_reg  :
                      free_found_reg ? free_way_reg : min_way_reg;

    // Store port control.
    always_comb
    begin
        line_rd_en   = 1'b0;
        line_rd_addr = {set_reg, way_reg};
        line_wr_en   = 1'b0;
        line_wr_addr = {set_reg, way_reg};
        line_wr_data = {1'b1, new_stamp, block_reg};
        clk_rd_en    = accept;
        clk_rd_addr  = in_set;
        clk_wr_en    = 1'b0;
        clk_wr_addr  = set_reg;
        clk_wr_data  = new_stamp;
        case (state_reg)
            S_CLEAR:
            begin
                line_wr_en   = 1'b1;
                line_wr_addr = clr_cnt_reg;
                line_wr_data = '0;
                clk_wr_en    = 1'b1;
                clk_wr_addr  = clr_cnt_reg[IDX_W-1:WAY_W];
                clk_wr_data  = '0;
            end
            S_READ:
            begin
                line_rd_en = 1'b1;
            end
            S_CHECK:
            begin
                // A flush invalidates the matching line and zeroes its stamp.
                if (mode_reg && rd_match)
                begin
                    line_wr_en   = 1'b1;
                    line_wr_data = {1'b0, {STAMP_W{1'b0}}, rd_block};
                end
            end
            S_UPDATE:
            begin
                if (!mode_reg)
                begin
                    line_wr_en   = 1'b1;
                    line_wr_addr = {set_reg, fill_way};
                    clk_wr_en    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (&clr_cnt_reg) state_next = S_IDLE;
            S_IDLE:   if (accept) state_next = S_READ;
            S_READ:   state_next = S_CHECK;
            S_CHECK:  state_next = (way_reg == last_way) ? S_UPDATE : S_READ;
            S_UPDATE: state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Capture a new request.
        if (accept)
        begin
            mode_reg       <= in_mode;
            block_reg      <= in_block;
            set_reg        <= in_set;
            way_reg        <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end

        // Evaluate one way: hit, first free way and lowest stamp.
        if (state_reg == S_CHECK)
        begin
            way_reg <= way_reg + 1'b1;
            if (rd_valid)
            begin
                if (!hit_found_reg && rd_match)
                begin
                    hit_found_reg <= 1'b1;
                    hit_way_reg   <= way_reg;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_way_reg   <= way_reg;
            end
            if ((way_reg == '0) || rd_lower)
            begin
                min_stamp_reg <= rd_stamp;
                min_way_reg   <= way_reg;
                min_block_reg <= rd_block;
            end
        end

        // Form the result.
        if (state_reg == S_UPDATE)
        begin
            res_victim_reg <= '0;
            if (mode_reg)
                res_status_reg <= ST_FLUSH;
            else if (hit_found_reg)
                res_status_reg <= ST_HIT;
            else if (free_found_reg)
                res_status_reg <= ST_MISS;
            else
            begin
                res_status_reg <= ST_EVICT;
                res_victim_reg <= min_block_reg;
            end
        end

        // Move the result into the output register once it is free.
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_insert_reg <= block_reg;
            out_victim_reg <= res_victim_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_insert = out_insert_reg;
    assign out_victim = out_victim_reg;

    // A new request always starts its scan at way zero.
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ) && (way_reg == '0))
        else $error("scan did not start at way zero");

    // The scan never looks past the ways in use.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (way_reg <= last_way))
        else $error("scan beyond the ways in use");

    // A fill always lands inside the ways in use.
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) && !mode_reg |-> (fill_way <= last_way))
        else $error("fill way beyond the ways in use");

endmodule

[tb/sal_checker.sv]
// Result checker for the set-associative LRU cache testbench.
// Watches the configuration, request and result channels, keeps its own cache
// state and compares every result in order; depends on sal_pkg.
`timescale 1ns / 100ps

module sal_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sal_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sal_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // address
    input  logic                            s_tuser,   // mode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [95:0]                     m_tdata,   // req_block, evict_block
    input  logic [1:0]                      m_tuser,   // status
    output int                              mismatches,
    output int                              outstanding
);
    import sal_pkg::*;

    localparam int ADDR_W = 48;
    localparam int SETS   = 64;
    localparam int WAYS   = 8;
    localparam int LINES  = SETS * WAYS;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] req_block;
        logic [ADDR_W-1:0] evict_block;
    } cache_result_t;

    // Shadow copy of the cache contents and the raw register values.
    logic                    line_ok  [LINES];
    logic [ADDR_W-1:0]       line_tag [LINES];
    logic [STAMP_W-1:0]      line_age [LINES];
    logic [STAMP_W-1:0]      set_uses [SETS];
    logic [SET_BITS_W-1:0]   set_bits_q;
    logic [BLOCK_BITS_W-1:0] block_bits_q;
    logic [WAYS_W-1:0]       ways_q;

    cache_result_t pending_results[$];
    cache_result_t want;

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] exp);
        $display("%0t: %s got %h, expected %h", $time, what, got, exp);
        mismatches++;
    endtask

    // Applies one request to the shadow cache and queues the result it must give.
    task automatic predict_lookup(input logic flush, input logic [ADDR_W-1:0] addr);
        int unsigned sb;
        int unsigned bb;
        int unsigned nw;
        int unsigned set_idx;
        int unsigned base;
        int unsigned fill;
        int unsigned w;
        int hit_way;
        int free_way;
        logic [ADDR_W-1:0] blk;
        logic [STAMP_W-1:0] oldest;
        cache_result_t res;

        // Clamp the geometry the same way the hardware does.
        sb = 32'(set_bits_q);
        while (sb > 0 && (1 << sb) > SETS)
            sb--;
        bb = 32'((block_bits_q > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_q);
        nw = (ways_q == 0) ? 1 : ((ways_q > WAYS) ? WAYS : 32'(ways_q));

        blk = (addr >> bb) << bb;
        set_idx = 32'((addr >> bb) & ((48'd1 << sb) - 48'd1));
        base = set_idx * WAYS;
        res.req_block = blk;
        res.evict_block = '0;

        if (flush)
        begin
            // A flush drops a matching line but leaves the set's counter alone.
            for (w = 0; w < nw; w++)
            begin
                if (line_ok[base + w] && line_tag[base + w] == blk)
                begin
                    line_ok[base + w] = 1'b0;
                    line_age[base + w] = '0;
                end
            end
            res.status = ST_FLUSH;
        end
        else
        begin
            hit_way = -1;
            free_way = -1;
            for (w = 0; w < nw; w++)
            begin
                if (line_ok[base + w])
                begin
                    if (hit_way < 0 && line_tag[base + w] == blk)
                        hit_way = int'(w);
                end
                else if (free_way < 0)
                begin
                    free_way = int'(w);
                end
            end
            set_uses[set_idx] = set_uses[set_idx] + 1'b1;
            if (hit_way >= 0)
            begin
                line_age[base + hit_way] = set_uses[set_idx];
                res.status = ST_HIT;
            end
            else
            begin
                if (free_way >= 0)
                begin
                    fill = unsigned'(free_way);
                    res.status = ST_MISS;
                end
                else
                begin
                    // Full set: the lowest stamp loses, first way on a tie.
                    oldest = line_age[base];
                    fill = 0;
                    for (w = 1; w < nw; w++)
                    begin
                        if (line_age[base + w] < oldest)
                        begin
                            oldest = line_age[base + w];
                            fill = w;
                        end
                    end
                    res.evict_block = line_tag[base + fill];
                    res.status = ST_EVICT;
                end
                line_ok[base + fill] = 1'b1;
                line_tag[base + fill] = blk;
                line_age[base + fill] = set_uses[set_idx];
            end
        end
        pending_results.push_back(res);
    endtask

    // Track register writes, predict each accepted request, check each result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                line_ok[i] = 1'b0;
                line_tag[i] = '0;
                line_age[i] = '0;
            end
            for (int i = 0; i < SETS; i++)
                set_uses[i] = '0;
            set_bits_q = SET_BITS_RST;
            block_bits_q = BLOCK_BITS_RST;
            ways_q = WAYS_RST;
            pending_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_q = cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_q = cfg_data[BLOCK_BITS_W-1:0];
                    CFG_WAYS:       ways_q = cfg_data[WAYS_W-1:0];
                    default:        ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_lookup(s_tuser, s_tdata);

            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("result with no request waiting, request block",
                                  m_tdata[47:0], '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser != want.status)
                        flag_mismatch("status", 48'(m_tuser), 48'(want.status));
                    if (m_tdata[47:0] != want.req_block)
                        flag_mismatch("request block", m_tdata[47:0], want.req_block);
                    if (m_tdata[95:48] != want.evict_block)
                        flag_mismatch("evicted block", m_tdata[95:48], want.evict_block);
                end
            end

            outstanding = pending_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Top of the set-associative LRU cache testbench: clock, reset and stimulus.
// Drives the cache and sal_checker side by side and prints the verdict;
// depends on sal_pkg, set_assoc_lru_cache and sal_checker.
`timescale 1ns / 100ps

module tb_top;

    import sal_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam bit  MODE_ACCESS = 1'b0;
    localparam bit  MODE_FLUSH  = 1'b1;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;   // address
    logic                   s_tuser;   // mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [95:0]            m_tdata;   // req_block, evict_block
    logic [1:0]             m_tuser;   // status

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int next_gap = 0;
    bit sender_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    int eff_sb = 4;
    int eff_bb = 4;

    set_assoc_lru_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    sal_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle cycles before a request or a result; none while the side is quiet.
    function automatic int draw_wait(input bit quiet);
        if (quiet)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 16);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [47:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[47:0];
    endfunction

    // Forces the set index of an address under the current geometry.
    function automatic logic [47:0] place_in_set(input logic [47:0] addr, input int set_idx);
        int lo;
        lo = eff_bb + eff_sb;
        return ((addr >> lo) << lo)
             | ((48'(set_idx) & ((48'd1 << eff_sb) - 48'd1)) << eff_bb);
    endfunction

    // Sends one request; valid stays high only when the next one follows at once.
    task automatic send(input bit mode, input logic [47:0] addr);
        repeat (next_gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        next_gap = draw_wait(sender_quiet);
        if (next_gap > 0)
            s_tvalid = 1'b0;
    endtask

    // Holds off new requests until every result is back.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // One register write; valid is left high so writes can run back to back.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [7:0] sb_raw, input logic [7:0] bb_raw,
                                input logic [7:0] ways_raw);
        wait_drained();
        cfg_write(CFG_SET_BITS, sb_raw);
        cfg_write(CFG_BLOCK_BITS, bb_raw);
        cfg_write(CFG_WAYS, ways_raw);
        cfg_valid = 1'b0;
        eff_sb = (sb_raw[2:0] > 6) ? 6 : sb_raw[2:0];
        eff_bb = (bb_raw[4:0] > 16) ? 16 : bb_raw[4:0];
    endtask

    // Random traffic drawn mostly from a small pool of blocks packed into a few
    // sets, so hits, refills and evictions all show up; some noise on top.
    task automatic random_phase(input int count);
        logic [47:0] pool [24];
        logic [47:0] addr;
        int pool_n;
        int set_span;
        bit flush;
        pool_n = $urandom_range(2, 24);
        set_span = $urandom_range(0, 3);
        for (int k = 0; k < pool_n; k++)
            pool[k] = place_in_set(rand_addr(), $urandom_range(0, set_span));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                addr = rand_addr();
            else
                addr = pool[$urandom_range(0, pool_n - 1)]
                     | (rand_addr() & ((48'd1 << eff_bb) - 48'd1));
            flush = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 15) == 0)
                sender_quiet = ~sender_quiet;
            send(flush ? MODE_FLUSH : MODE_ACCESS, addr);
        end
    endtask

    // Result side: random stalls before each result, with quiet stretches.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            if ($urandom_range(0, 31) == 0)
                sink_quiet = ~sink_quiet;
            stall = draw_wait(sink_quiet);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_BITS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = MODE_ACCESS;
        s_tdata = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset geometry: 16 sets, 16-byte blocks, 8 ways.
        send(MODE_ACCESS, 48'h0);
        send(MODE_ACCESS, 48'h00F);
        send(MODE_ACCESS, 48'hFFFF_FFFF_FFFF);
        send(MODE_FLUSH,  48'hFFFF_FFFF_FFF0);
        send(MODE_FLUSH,  48'hFFFF_FFFF_FFF0);
        send(MODE_ACCESS, 48'hFFFF_FFFF_FFF7);
        send(MODE_FLUSH,  48'h5555_5555_5555);
        send(MODE_ACCESS, 48'hAAAA_AAAA_AAAA);
        // Fill set 3, touch the oldest line, then force two evictions.
        for (int t = 1; t <= 8; t++)
            send(MODE_ACCESS, (48'(t) << 8) | 48'h30);
        send(MODE_ACCESS, 48'h130);
        send(MODE_ACCESS, 48'h930);
        send(MODE_ACCESS, 48'h230);
        // Flush an evicted block with offset bits set, then access it again: another eviction.
        send(MODE_FLUSH,  48'h33C);
        send(MODE_ACCESS, 48'h330);

        // Extremes: one set, byte blocks, a single way.
        set_geometry(8'd0, 8'd0, 8'd1);
        random_phase(60);
        set_geometry(8'd6, 8'd16, 8'd8);
        random_phase(80);
        // All ones: every field clamps, the spare index must be ignored.
        wait_drained();
        cfg_write(CFG_SPARE, 8'hFF);
        set_geometry(8'hFF, 8'hFF, 8'hFF);
        random_phase(80);
        set_geometry(8'd3, 8'd17, 8'd0);
        random_phase(60);
        // Shrink the ways and grow them back: idle lines must keep their state.
        set_geometry(8'd4, 8'd4, 8'd2);
        random_phase(60);
        set_geometry(8'd4, 8'd4, 8'd8);
        random_phase(60);
        for (int p = 0; p < 4; p++)
        begin
            set_geometry(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            sender_quiet = 1'($urandom_range(0, 1));
            random_phase(75);
        end

        wait_drained();
        repeat (64) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
